// ===== rtl/core/mafr_pkg.sv =====
// Shared types, character codes and the hex digit decoder of the ASCII frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package mafr_pkg;

    // Item kind on the request side
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Framing characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPF   = 8'h46;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam int          TDATA_W       = 32;
    localparam int          TDATA_PAD     = 6;

    typedef enum logic [1:0] {
        RK_DATA   = 2'd0,
        RK_ACCEPT = 2'd1,
        RK_REJECT = 2'd2
    } t_rkind;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_FRAME   = 2'd1,
        ERR_LRC     = 2'd2,
        ERR_TIMEOUT = 2'd3
    } t_err;

    typedef struct packed {
        t_rkind      kind;
        logic [7:0]  data;
        logic [7:0]  addr;
        logic [7:0]  func;
        t_err        err;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    // Upper-case hex digit to nibble; valid low for anything else
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.valid = 1'b1;
            h.value = 4'(c - CH_ZERO);
        end else if (c >= CH_UPA && c <= CH_UPF) begin
            h.valid = 1'b1;
            h.value = 4'(c - CH_UPA + 8'd10);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/modbus_ascii_frame_receiver_top.sv =====
// Top level of the ASCII frame receiver: character decode, LRC check and result queue.
`timescale 1ns / 1ps
`default_nettype none

// ASCII frame receiver with LRC check. Each request is either one received
// character (tuser low, character in tdata) or one timer tick (tuser high). A
// frame is ':' followed by pairs of upper-case hex digits (address, function,
// data bytes, LRC) closed by CR LF. Every byte after the function code is
// held back by one byte, so the last one is checked as the LRC at LF; data
// bytes leave as they are displaced. At LF the block reports accept or
// reject; bad characters, misplaced CR/LF, an odd digit before CR, a frame
// of fewer than three bytes, an LRC mismatch or timeout_ticks ticks without a
// character (0 acts as 1) reject the frame with an error code and reset the
// receiver. Rate: one request per clock while the skid register is free. Each
// request is decoded combinationally from the state registers into a
// two-entry result queue (output register plus skid register); the request
// side stalls only while both entries are full, so requests that make no
// result keep flowing while a result waits. Each result is registered. The
// user must write the timeout register through i_cfg_wr_en/i_cfg_wr_data only
// while the block is idle (not enforced by the block); it resets to 1000.
module modbus_ascii_frame_receiver_top
    import mafr_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_wr_en,
    input  wire  [15:0]         i_cfg_wr_data,   // timeout_ticks
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [7:0]          s_axis_tdata,    // [7:0] rx_char
    input  wire                 s_axis_tuser,    // [0] kind
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [TDATA_W-1:0]  m_axis_tdata,    // [7:0] data_byte, [15:8] frame_address,
                                                 // [23:16] frame_function, [25:24] error_code
    output logic [1:0]          m_axis_tuser     // [1:0] result_kind
);

    // Configuration
    logic [15:0] r_timeout;

    // Receiver state
    logic        r_in_frame,  n_in_frame;
    logic        r_cr_seen,   n_cr_seen;
    logic        r_nib_pend,  n_nib_pend;
    logic [3:0]  r_high_nib,  n_high_nib;
    logic [1:0]  r_bytes,     n_bytes;
    logic [7:0]  r_address,   n_address;
    logic [7:0]  r_function,  n_function;
    logic [7:0]  r_held,      n_held;
    logic        r_held_vld,  n_held_vld;
    logic [7:0]  r_lrc,       n_lrc;
    logic [15:0] r_idle,      n_idle;

    // Result queue
    logic        r_out_vld;
    t_result     r_out;
    logic        r_skd_vld;
    t_result     r_skd;

    logic        w_req_acc;
    logic        w_pop;
    logic        w_res_vld;
    t_result     w_res;

    assign s_axis_tready = !r_skd_vld;
    assign w_req_acc     = s_axis_tvalid && s_axis_tready;
    assign w_pop         = r_out_vld && m_axis_tready;

    // ---------------------------------------------------------------
    // Single-pass decode of one request
    // ---------------------------------------------------------------
    always_comb begin
        logic        clr;
        logic [15:0] idle_inc;
        logic [15:0] limit;
        logic [7:0]  c;
        logic [7:0]  b;
        t_hex        hx;

        clr        = 1'b0;
        c          = s_axis_tdata;
        hx         = hex_decode(c);
        b          = {r_high_nib, hx.value};
        idle_inc   = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
        limit      = (r_timeout == 16'd0) ? 16'd1 : r_timeout;

        n_in_frame = r_in_frame;
        n_cr_seen  = r_cr_seen;
        n_nib_pend = r_nib_pend;
        n_high_nib = r_high_nib;
        n_bytes    = r_bytes;
        n_address  = r_address;
        n_function = r_function;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_lrc      = r_lrc;
        n_idle     = r_idle;

        // Address and function go out as they stand before any clear
        w_res_vld  = 1'b0;
        w_res.kind = RK_REJECT;
        w_res.data = 8'd0;
        w_res.addr = r_address;
        w_res.func = r_function;
        w_res.err  = ERR_FRAME;

        if (s_axis_tuser == KIND_TICK) begin
            if (r_in_frame) begin
                n_idle = idle_inc;
                if (idle_inc >= limit) begin
                    w_res_vld = 1'b1;
                    w_res.err = ERR_TIMEOUT;
                    clr       = 1'b1;
                end
            end
        end else if (!r_in_frame) begin
            clr = 1'b1;
            if (c != CH_COLON) begin
                w_res_vld = 1'b1;
            end
        end else begin
            n_idle = 16'd0;
            if (c == CH_LF) begin
                clr       = 1'b1;
                w_res_vld = 1'b1;
                if (!r_cr_seen || r_bytes != 2'd3 || !r_held_vld) begin
                    w_res.err = ERR_FRAME;
                end else if (8'(8'd0 - r_lrc) != r_held) begin
                    w_res.err = ERR_LRC;
                end else begin
                    w_res.kind = RK_ACCEPT;
                    w_res.err  = ERR_NONE;
                end
            end else if (r_cr_seen) begin
                clr       = 1'b1;
                w_res_vld = 1'b1;
            end else if (c == CH_CR) begin
                if (r_nib_pend) begin
                    clr       = 1'b1;
                    w_res_vld = 1'b1;
                end else begin
                    n_cr_seen = 1'b1;
                end
            end else if (!hx.valid) begin
                clr       = 1'b1;
                w_res_vld = 1'b1;
            end else if (!r_nib_pend) begin
                n_high_nib = hx.value;
                n_nib_pend = 1'b1;
            end else begin
                n_nib_pend = 1'b0;
                case (r_bytes)
                    2'd0: begin
                        n_address = b;
                        n_lrc     = r_lrc + b;
                        n_bytes   = 2'd1;
                    end
                    2'd1: begin
                        n_function = b;
                        n_lrc      = r_lrc + b;
                        n_bytes    = 2'd2;
                    end
                    default: begin
                        n_bytes = 2'd3;
                        n_held  = b;
                        if (r_held_vld) begin
                            // Displace the held byte: it was data, not the LRC
                            n_lrc      = r_lrc + r_held;
                            w_res_vld  = 1'b1;
                            w_res.kind = RK_DATA;
                            w_res.data = r_held;
                            w_res.err  = ERR_NONE;
                        end else begin
                            n_held_vld = 1'b1;
                        end
                    end
                endcase
            end
        end

        // Receiver reset; an opening colon lands here too and opens the frame
        if (clr) begin
            n_in_frame = (s_axis_tuser == KIND_CHAR) && !r_in_frame && (c == CH_COLON);
            n_cr_seen  = 1'b0;
            n_nib_pend = 1'b0;
            n_high_nib = 4'd0;
            n_bytes    = 2'd0;
            n_address  = 8'd0;
            n_function = 8'd0;
            n_held     = 8'd0;
            n_held_vld = 1'b0;
            n_lrc      = 8'd0;
            n_idle     = 16'd0;
        end
    end

    // ---------------------------------------------------------------
    // Configuration and receiver state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_cr_seen  <= 1'b0;
            r_nib_pend <= 1'b0;
            r_high_nib <= 4'd0;
            r_bytes    <= 2'd0;
            r_address  <= 8'd0;
            r_function <= 8'd0;
            r_held     <= 8'd0;
            r_held_vld <= 1'b0;
            r_lrc      <= 8'd0;
            r_idle     <= 16'd0;
        end else if (w_req_acc) begin
            r_in_frame <= n_in_frame;
            r_cr_seen  <= n_cr_seen;
            r_nib_pend <= n_nib_pend;
            r_high_nib <= n_high_nib;
            r_bytes    <= n_bytes;
            r_address  <= n_address;
            r_function <= n_function;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_lrc      <= n_lrc;
            r_idle     <= n_idle;
        end
    end

    // ---------------------------------------------------------------
    // Result queue: output register backed by a skid register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (w_pop) begin
            if (r_skd_vld) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= w_req_acc && w_res_vld;
            end
        end else if (w_req_acc && w_res_vld) begin
            if (r_out_vld) begin
                r_skd_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skd_vld) begin
                r_out <= r_skd;
            end else begin
                r_out <= w_res;
            end
        end else if (w_req_acc && w_res_vld) begin
            if (r_out_vld) begin
                r_skd <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {{TDATA_PAD{1'b0}}, r_out.err, r_out.func, r_out.addr, r_out.data};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid entry held with empty output register");

    a_result_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_acc && w_res_vld) |=> r_out_vld)
        else $error("result of an accepted request was not queued");

    a_reject_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_acc && w_res_vld && w_res.kind == RK_REJECT) |=> !r_in_frame && !r_held_vld)
        else $error("receiver not reset after a rejected frame");

    a_bytes_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes != 2'd0 || r_held_vld || r_cr_seen) |-> r_in_frame)
        else $error("frame progress recorded outside a frame");

    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_acc && w_res_vld && w_res.kind == RK_ACCEPT)
            |-> (w_res.err == ERR_NONE && 8'(r_lrc + r_held) == 8'd0))
        else $error("frame accepted with a bad LRC or an error code");

endmodule

`default_nettype wire
